// ===== rtl/dmxut_pkg.sv =====
// Shared constants, codes and types of the DMX universe transmitter.
package dmxut_pkg;

  localparam int unsigned MAX_SLOTS  = 512;
  localparam int unsigned SLOT_DEPTH = MAX_SLOTS + 1;
  localparam int unsigned SLOT_W     = $clog2(SLOT_DEPTH);
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned KIND_W     = 3;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = SLOT_W;

  localparam logic [CFG_IDX_W-1:0] CFG_SLOT_COUNT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_TX_ENABLE  = CFG_IDX_W'(1);

  typedef enum logic [MODE_W-1:0] {
    MODE_WRITE = 2'd0,
    MODE_READ  = 2'd1,
    MODE_CLEAR = 2'd2,
    MODE_TICK  = 2'd3
  } mode_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_BREAK = 3'd0,
    KIND_SLOT  = 3'd1,
    KIND_READ  = 3'd2,
    KIND_ACK   = 3'd3,
    KIND_ERROR = 3'd4
  } kind_e;

  typedef enum logic {
    ST_CLEAR = 1'b0,
    ST_RUN   = 1'b1
  } ctl_state_e;

  typedef struct packed {
    logic              valid;
    kind_e             kind;
    logic [SLOT_W-1:0] slot_index;
    logic              frame_end;
    logic              use_mem;
  } pend_t;

  typedef struct packed {
    logic clearing;
  } ctl_sts_t;

endpackage

// ===== rtl/dmxut_if.sv =====
// Request, result and configuration channel interfaces.
interface dmxut_cmd_if;
  logic                          valid;
  logic                          ready;
  logic [dmxut_pkg::MODE_W-1:0]  mode;
  logic [dmxut_pkg::SLOT_W-1:0]  address;
  logic [dmxut_pkg::BYTE_W-1:0]  value;

  modport source (output valid, mode, address, value, input ready);
  modport sink (input valid, mode, address, value, output ready);
endinterface

interface dmxut_res_if;
  logic                          valid;
  logic                          ready;
  logic [dmxut_pkg::KIND_W-1:0]  kind;
  logic [dmxut_pkg::BYTE_W-1:0]  byte_out;
  logic [dmxut_pkg::SLOT_W-1:0]  slot_index;
  logic                          frame_end;

  modport source (output valid, kind, byte_out, slot_index, frame_end, input ready);
  modport sink (input valid, kind, byte_out, slot_index, frame_end, output ready);
endinterface

interface dmxut_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [dmxut_pkg::CFG_IDX_W-1:0]   index;
  logic [dmxut_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/dmxut_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module dmxut_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/dmxut_ctrl.sv =====
// Request decode, configuration registers, frame position and clearing sweep.
module dmxut_ctrl (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  dmxut_cmd_if.sink                      cmd_i,
  dmxut_cfg_if.sink                      cfg_i,
  input  logic                           space_i,
  output dmxut_pkg::pend_t               req_o,
  output dmxut_pkg::ctl_sts_t            sts_o,
  output logic                           ram_we_o,
  output logic [dmxut_pkg::SLOT_W-1:0]   ram_waddr_o,
  output logic [dmxut_pkg::BYTE_W-1:0]   ram_wdata_o,
  output logic                           ram_re_o,
  output logic [dmxut_pkg::SLOT_W-1:0]   ram_raddr_o
);

  dmxut_pkg::ctl_state_e             state_q, state_d;
  logic [dmxut_pkg::SLOT_W-1:0]      clr_addr_q, clr_addr_d;
  logic [dmxut_pkg::SLOT_W-1:0]      pos_q, pos_d;
  logic [dmxut_pkg::SLOT_W-1:0]      slot_count_q;
  logic                              tx_en_q;
  logic [dmxut_pkg::SLOT_W-1:0]      count_eff;
  logic [dmxut_pkg::SLOT_W-1:0]      slot;
  logic                              accept;
  logic                              in_range;
  logic                              frame_cut;
  logic                              last;
  logic                              clear_done;

  localparam logic [dmxut_pkg::SLOT_W-1:0] MaxSlot = dmxut_pkg::SLOT_W'(dmxut_pkg::MAX_SLOTS);
  localparam logic [dmxut_pkg::SLOT_W-1:0] One     = dmxut_pkg::SLOT_W'(1);

  assign cfg_i.ready = 1'b1;
  assign cmd_i.ready = (state_q == dmxut_pkg::ST_RUN) && space_i;
  assign accept      = cmd_i.valid && cmd_i.ready;
  assign clear_done  = (clr_addr_q == MaxSlot);

  always_comb begin
    count_eff = slot_count_q;
    if (slot_count_q == '0) begin
      count_eff = One;
    end else if (slot_count_q > MaxSlot) begin
      count_eff = MaxSlot;
    end
  end

  assign in_range  = (cmd_i.address != '0) && (cmd_i.address <= count_eff);
  assign slot      = pos_q - One;
  assign frame_cut = (pos_q == '0) || (slot > count_eff);
  assign last      = (slot == count_eff);

  always_comb begin
    state_d    = state_q;
    clr_addr_d = '0;
    unique case (state_q)
      dmxut_pkg::ST_CLEAR: begin
        if (clear_done) begin
          state_d = dmxut_pkg::ST_RUN;
        end else begin
          clr_addr_d = clr_addr_q + One;
        end
      end
      dmxut_pkg::ST_RUN: begin
        if (accept && (dmxut_pkg::mode_e'(cmd_i.mode) == dmxut_pkg::MODE_CLEAR)) begin
          state_d = dmxut_pkg::ST_CLEAR;
        end
      end
      default: state_d = dmxut_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    req_o       = '0;
    pos_d       = pos_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = cmd_i.address;
    ram_wdata_o = cmd_i.value;
    ram_re_o    = 1'b0;
    ram_raddr_o = cmd_i.address;
    sts_o.clearing = (state_q == dmxut_pkg::ST_CLEAR);
    unique case (state_q)
      dmxut_pkg::ST_CLEAR: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = clr_addr_q;
        ram_wdata_o = '0;
      end
      dmxut_pkg::ST_RUN: begin
        if (accept) begin
          unique case (dmxut_pkg::mode_e'(cmd_i.mode))
            dmxut_pkg::MODE_WRITE: begin
              req_o.valid = 1'b1;
              req_o.kind  = in_range ? dmxut_pkg::KIND_ACK : dmxut_pkg::KIND_ERROR;
              ram_we_o    = in_range;
            end
            dmxut_pkg::MODE_READ: begin
              req_o.valid = 1'b1;
              if (in_range) begin
                req_o.kind       = dmxut_pkg::KIND_READ;
                req_o.slot_index = cmd_i.address;
                req_o.use_mem    = 1'b1;
                ram_re_o         = 1'b1;
              end else begin
                req_o.kind = dmxut_pkg::KIND_ERROR;
              end
            end
            dmxut_pkg::MODE_CLEAR: begin
              req_o.valid = 1'b1;
              req_o.kind  = dmxut_pkg::KIND_ACK;
            end
            dmxut_pkg::MODE_TICK: begin
              if (!tx_en_q) begin
                pos_d = '0;
              end else if (frame_cut) begin
                req_o.valid = 1'b1;
                req_o.kind  = dmxut_pkg::KIND_BREAK;
                pos_d       = One;
              end else begin
                req_o.valid      = 1'b1;
                req_o.kind       = dmxut_pkg::KIND_SLOT;
                req_o.slot_index = slot;
                req_o.frame_end  = last;
                req_o.use_mem    = 1'b1;
                ram_re_o         = 1'b1;
                ram_raddr_o      = slot;
                pos_d            = last ? '0 : pos_q + One;
              end
            end
            default: req_o = '0;
          endcase
        end
      end
      default: ram_we_o = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= dmxut_pkg::ST_CLEAR;
      clr_addr_q   <= '0;
      pos_q        <= '0;
      slot_count_q <= MaxSlot;
      tx_en_q      <= 1'b1;
    end else begin
      state_q    <= state_d;
      clr_addr_q <= clr_addr_d;
      pos_q      <= pos_d;
      if (cfg_i.valid && cfg_i.ready) begin
        if (cfg_i.index == dmxut_pkg::CFG_SLOT_COUNT) begin
          slot_count_q <= cfg_i.data[dmxut_pkg::SLOT_W-1:0];
        end else if (cfg_i.index == dmxut_pkg::CFG_TX_ENABLE) begin
          tx_en_q <= cfg_i.data[0];
        end
      end
    end
  end

endmodule

// ===== rtl/dmxut_resp.sv =====
// Pending stage that merges memory read data, followed by the result register.
module dmxut_resp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  dmxut_pkg::pend_t              req_i,
  input  logic [dmxut_pkg::BYTE_W-1:0]  rdata_i,
  output logic                          space_o,
  dmxut_res_if.source                   res_o
);

  dmxut_pkg::pend_t              pend_q;
  logic                          out_valid_q;
  dmxut_pkg::kind_e              kind_q;
  logic [dmxut_pkg::BYTE_W-1:0]  byte_q;
  logic [dmxut_pkg::SLOT_W-1:0]  idx_q;
  logic                          end_q;
  logic                          move;

  assign space_o = !out_valid_q || res_o.ready;
  assign move    = pend_q.valid && space_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (space_o) begin
        pend_q      <= req_i;
        out_valid_q <= pend_q.valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (move) begin
      kind_q <= pend_q.kind;
      byte_q <= pend_q.use_mem ? rdata_i : '0;
      idx_q  <= pend_q.slot_index;
      end_q  <= pend_q.frame_end;
    end
  end

  assign res_o.valid      = out_valid_q;
  assign res_o.kind       = kind_q;
  assign res_o.byte_out   = byte_q;
  assign res_o.slot_index = idx_q;
  assign res_o.frame_end  = end_q;

endmodule

// ===== rtl/dmx_universe_transmitter_core.sv =====
// Top level of the DMX universe transmitter.
// The block holds 513 slot bytes, slot 0 being the start code, in one RAM.
// Requests arrive on cmd_i: write, read, clear all, or transmit tick. Each
// request gives at most one result on res_o; a tick while sending is off
// gives none. Configuration writes on cfg_i set the slot count (index 0) and
// the send enable (index 1); they are always ready and take effect at once.
// A request's result passes through the pending stage, which meets the slot
// RAM read data, and then the result register before it is valid on res_o.
// While results are taken, one request is accepted every cycle. After reset,
// and after every clear request, a sweep writes zero into all 513 entries,
// one per cycle, and cmd_i is not ready during the sweep; results still
// drain and configuration writes are still taken during the sweep.
// When the receiver stalls, the result register holds, one further request
// is held in the pending stage, and cmd_i then drops ready.
// Reset sets the slot count to 512, enables sending and restarts the frame.
module dmx_universe_transmitter_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  dmxut_cmd_if.sink    cmd_i,
  dmxut_cfg_if.sink    cfg_i,
  dmxut_res_if.source  res_o
);

  dmxut_pkg::pend_t              req;
  dmxut_pkg::ctl_sts_t           sts;
  logic                          space;
  logic                          ram_we;
  logic [dmxut_pkg::SLOT_W-1:0]  ram_waddr;
  logic [dmxut_pkg::BYTE_W-1:0]  ram_wdata;
  logic                          ram_re;
  logic [dmxut_pkg::SLOT_W-1:0]  ram_raddr;
  logic [dmxut_pkg::BYTE_W-1:0]  ram_rdata;

  dmxut_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_i),
    .cfg_i       (cfg_i),
    .space_i     (space),
    .req_o       (req),
    .sts_o       (sts),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr)
  );

  dmxut_ram #(
    .Width (dmxut_pkg::BYTE_W),
    .Depth (dmxut_pkg::SLOT_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  dmxut_resp u_resp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req),
    .rdata_i (ram_rdata),
    .space_o (space),
    .res_o   (res_o)
  );

  a_no_accept_in_sweep : assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts.clearing |-> !(cmd_i.valid && cmd_i.ready))
    else $error("Request accepted during the clearing sweep.");

  a_write_source : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && !sts.clearing) |->
      (cmd_i.valid && cmd_i.ready &&
       (cmd_i.mode == dmxut_pkg::MODE_WRITE)))
    else $error("Slot RAM written outside a write request or the sweep.");

  a_mem_result_reads : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req.valid && req.use_mem) |-> ram_re)
    else $error("Result needs slot data but no RAM read was issued.");

  a_frame_end_on_slot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.frame_end) |-> (res_o.kind == dmxut_pkg::KIND_SLOT))
    else $error("Frame end flagged on a result that is not a slot byte.");

endmodule
